### sv/csp_pkg.sv
// Package for the color string parser: character codes, result form codes
// and the result beat type. No dependencies.

package csp_pkg;

	localparam int unsigned CHAR_W = 8;
	localparam int unsigned FORM_W = 2;
	localparam int unsigned COMP_W = 8;

	localparam logic [CHAR_W-1:0] CH_BLANK_MAX = 8'h20;
	localparam logic [CHAR_W-1:0] CH_HASH      = 8'h23;
	localparam logic [CHAR_W-1:0] CH_PLUS      = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_COMMA     = 8'h2C;
	localparam logic [CHAR_W-1:0] CH_MINUS     = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_DIGIT_0   = 8'h30;
	localparam logic [CHAR_W-1:0] CH_DIGIT_9   = 8'h39;
	localparam logic [CHAR_W-1:0] CH_UPPER_A   = 8'h41;
	localparam logic [CHAR_W-1:0] CH_UPPER_F   = 8'h46;
	localparam logic [CHAR_W-1:0] CH_LOWER_A   = 8'h61;
	localparam logic [CHAR_W-1:0] CH_LOWER_F   = 8'h66;
	localparam logic [CHAR_W-1:0] CH_LOWER_R   = 8'h72;
	localparam logic [CHAR_W-1:0] CH_LOWER_G   = 8'h67;
	localparam logic [CHAR_W-1:0] CH_LOWER_B   = 8'h62;
	localparam logic [CHAR_W-1:0] CASE_BIT     = 8'h20;
	localparam logic [CHAR_W-1:0] UPPER_HEX_OFS = 8'h37;
	localparam logic [CHAR_W-1:0] LOWER_HEX_OFS = 8'h57;
	localparam logic [COMP_W-1:0] COMP_MAX     = 8'hFF;

	localparam logic [FORM_W-1:0] FORM_SHORT_HEX = 2'd0;
	localparam logic [FORM_W-1:0] FORM_LONG_HEX  = 2'd1;
	localparam logic [FORM_W-1:0] FORM_RGB       = 2'd2;

	typedef struct packed {
		logic              valid_res;
		logic [FORM_W-1:0] form;
		logic [COMP_W-1:0] red;
		logic [COMP_W-1:0] green;
		logic [COMP_W-1:0] blue;
	} color_res_t;

endpackage

### sv/csp_if.sv
// Handshake channels of the color string parser: character beats in,
// color beats out. Depends on csp_pkg.

interface csp_char_if import csp_pkg::*;;
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] char_code;
	logic              last_char;

	modport source (output valid, output char_code, output last_char, input ready);
	modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface csp_color_if import csp_pkg::*;;
	logic              valid;
	logic              ready;
	logic              valid_res;
	logic [FORM_W-1:0] form;
	logic [COMP_W-1:0] red;
	logic [COMP_W-1:0] green;
	logic [COMP_W-1:0] blue;

	modport source (output valid, output valid_res, output form, output red, output green,
		output blue, input ready);
	modport sink   (input valid, input valid_res, input form, input red, input green,
		input blue, output ready);
endinterface

### sv/css_color_string_parser.sv
// Color string parser top level: per-byte parser state and the result register.
// Depends on csp_pkg and the channel interfaces in csp_if.sv.
//
//   channel  dir  beat                      when
//   chars    in   char_code, last_char      one byte of the string per beat
//   colors   out  valid_res, form, r, g, b  one beat per final byte
//
// One byte is taken every cycle while chars is not stalled; the parser state updates in the same cycle.
// The color beat appears in the cycle after the final byte is taken.
// chars stalls only while a color beat waits in the result register and
// colors.ready is low. Reset clears the parser state and the result register.

module css_color_string_parser import csp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	csp_char_if.sink          chars,
	csp_color_if.source       colors
);

	localparam int unsigned STEP_PASSES = 6;

	typedef enum logic [2:0] {
		PH_LEAD, PH_KEYWORD, PH_SKIPONE, PH_SEPARATOR, PH_DIGITS, PH_HEX, PH_DONE
	} phase_t;

	typedef enum logic [1:0] {DF_NONE, DF_FAIL, DF_HEX, DF_RGB} done_t;

	typedef struct packed {
		phase_t            phase;
		logic [23:0]       hex;
		logic [2:0]        dcount;
		logic [COMP_W-1:0] acc;
		logic              neg;
		logic [1:0]        idx;
		logic [2:0]        after;
		logic [1:0]        kw;
		logic [COMP_W-1:0] red;
		logic [COMP_W-1:0] green;
		logic [COMP_W-1:0] blue;
		done_t             done;
	} parse_t;

	localparam parse_t PARSE_RESET = '{
		phase: PH_LEAD, hex: '0, dcount: '0, acc: '0, neg: 1'b0, idx: '0, after: '0,
		kw: '0, red: '0, green: '0, blue: '0, done: DF_NONE};

	function automatic parse_t parse_step(input parse_t s, input logic [CHAR_W-1:0] ch,
		input logic last, input logic [COMP_W-1:0] mac, output logic again);
		parse_t            n;
		logic [COMP_W-1:0] comp;
		logic [3:0]        nib;
		n     = s;
		again = 1'b0;
		comp  = '0;
		nib   = '0;
		case (s.phase)
			PH_LEAD: begin
				if (ch > CH_BLANK_MAX) begin
					if (ch == CH_HASH) begin
						n.phase  = PH_HEX;
						n.hex    = '0;
						n.dcount = '0;
					end else if ((ch | CASE_BIT) == CH_LOWER_R) begin
						n.phase = PH_KEYWORD;
						n.kw    = 2'd1;
					end else begin
						n.phase = PH_DONE;
						n.done  = DF_FAIL;
					end
				end
			end
			PH_KEYWORD: begin
				if (s.kw == 2'd1 && (ch | CASE_BIT) == CH_LOWER_G) begin
					n.kw = 2'd2;
				end else if (s.kw == 2'd2 && (ch | CASE_BIT) == CH_LOWER_B) begin
					n.phase = PH_SKIPONE;
					n.after = '0;
				end else begin
					n.phase = PH_DONE;
					n.done  = DF_FAIL;
				end
			end
			PH_SKIPONE: begin
				n.phase = PH_SEPARATOR;
				n.idx   = '0;
			end
			PH_SEPARATOR: begin
				if (!(ch <= CH_BLANK_MAX || (ch == CH_COMMA && s.idx != 2'd0))) begin
					if (last) begin
						n.phase = PH_DONE;
						n.done  = DF_FAIL;
					end else begin
						n.dcount = '0;
						n.acc    = '0;
						n.neg    = 1'b0;
						n.phase  = PH_DIGITS;
						if (ch == CH_MINUS) begin
							n.neg = 1'b1;
						end else if (ch != CH_PLUS) begin
							again = 1'b1;
						end
					end
				end
			end
			PH_DIGITS: begin
				if (ch inside {[CH_DIGIT_0:CH_DIGIT_9]}) begin
					n.acc = (s.dcount == 3'd0) ? (ch - CH_DIGIT_0) : mac;
					if (s.dcount != 3'd7) begin
						n.dcount = s.dcount + 3'd1;
					end
				end else begin
					if (s.neg || s.dcount == 3'd0) begin
						comp = '0;
					end else if (s.dcount > 3'd3) begin
						comp = COMP_MAX;
					end else begin
						comp = s.acc;
					end
					if (s.idx == 2'd0) begin
						n.red   = comp;
						n.idx   = 2'd1;
						n.phase = PH_SEPARATOR;
						again   = 1'b1;
					end else if (s.idx == 2'd1) begin
						n.green = comp;
						n.idx   = 2'd2;
						n.phase = PH_SEPARATOR;
						again   = 1'b1;
					end else begin
						n.blue  = comp;
						n.done  = DF_RGB;
						n.phase = PH_DONE;
					end
				end
			end
			PH_HEX: begin
				if (ch inside {[CH_DIGIT_0:CH_DIGIT_9], [CH_UPPER_A:CH_UPPER_F],
					[CH_LOWER_A:CH_LOWER_F]}) begin
					if (ch inside {[CH_DIGIT_0:CH_DIGIT_9]}) begin
						nib = 4'(ch - CH_DIGIT_0);
					end else if (ch inside {[CH_UPPER_A:CH_UPPER_F]}) begin
						nib = 4'(ch - UPPER_HEX_OFS);
					end else begin
						nib = 4'(ch - LOWER_HEX_OFS);
					end
					n.hex = {s.hex[19:0], nib};
					if (s.dcount != 3'd7) begin
						n.dcount = s.dcount + 3'd1;
					end
				end else begin
					if (s.dcount == 3'd3) begin
						n.red   = {s.hex[11:8], s.hex[11:8]};
						n.green = {s.hex[7:4], s.hex[7:4]};
						n.blue  = {s.hex[3:0], s.hex[3:0]};
						n.done  = DF_HEX;
					end else if (s.dcount == 3'd6) begin
						n.red   = s.hex[23:16];
						n.green = s.hex[15:8];
						n.blue  = s.hex[7:0];
						n.done  = DF_HEX;
					end else begin
						n.done = DF_FAIL;
					end
					n.phase = PH_DONE;
				end
			end
			default: begin
			end
		endcase
		return n;
	endfunction

	parse_t     state_q;
	parse_t     state_next;
	color_res_t res_next;
	color_res_t res_q;
	logic       out_valid_q;
	logic       char_beat;

	assign chars.ready = !out_valid_q || colors.ready;
	assign char_beat   = chars.valid && chars.ready;

	always_comb begin
		parse_t            st;
		logic              pending;
		logic              again_w;
		logic [11:0]       mac_w;
		logic [COMP_W-1:0] mac;
		st      = state_q;
		pending = 1'b1;
		again_w = 1'b0;
		mac_w   = {4'b0, state_q.acc} * 12'd10 + {4'b0, chars.char_code - CH_DIGIT_0};
		mac     = (mac_w > {4'b0, COMP_MAX}) ? COMP_MAX : mac_w[COMP_W-1:0];
		if (st.phase == PH_SKIPONE || st.phase == PH_SEPARATOR || st.phase == PH_DIGITS ||
			(st.phase == PH_DONE && st.done == DF_RGB)) begin
			if (st.after != 3'd7) begin
				st.after = st.after + 3'd1;
			end
		end
		for (int i = 0; i < STEP_PASSES; i++) begin
			if (pending) begin
				st      = parse_step(st, chars.char_code, chars.last_char, mac, again_w);
				pending = again_w;
			end
		end
		state_next = st;

		res_next = '0;
		if (st.done == DF_HEX) begin
			res_next.valid_res = 1'b1;
			res_next.form = (st.dcount == 3'd6) ? FORM_LONG_HEX : FORM_SHORT_HEX;
		end else if (st.done == DF_RGB && st.after == 3'd7) begin
			res_next.valid_res = 1'b1;
			res_next.form      = FORM_RGB;
		end
		if (res_next.valid_res) begin
			res_next.red   = st.red;
			res_next.green = st.green;
			res_next.blue  = st.blue;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= PARSE_RESET;
			out_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			if (char_beat) begin
				state_q <= chars.last_char ? PARSE_RESET : state_next;
			end
			if (char_beat && chars.last_char) begin
				out_valid_q <= 1'b1;
				res_q       <= res_next;
			end else if (colors.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign colors.valid     = out_valid_q;
	assign colors.valid_res = res_q.valid_res;
	assign colors.form      = res_q.form;
	assign colors.red       = res_q.red;
	assign colors.green     = res_q.green;
	assign colors.blue      = res_q.blue;

	a_final_gives_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(char_beat && chars.last_char) |=> (colors.valid && state_q.phase == PH_LEAD))
		else $error("final byte did not produce a color beat and parser restart");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(colors.valid && !colors.valid_res) |-> (colors.form == FORM_SHORT_HEX &&
		colors.red == '0 && colors.green == '0 && colors.blue == '0))
		else $error("invalid color beat carries nonzero fields");

	a_form_legal: assert property (@(posedge clk) disable iff (!arst_n)
		(colors.valid && colors.valid_res) |-> (colors.form == FORM_SHORT_HEX ||
		colors.form == FORM_LONG_HEX || colors.form == FORM_RGB))
		else $error("valid color beat with undefined form");

	a_no_beat_mid_string: assert property (@(posedge clk) disable iff (!arst_n)
		(!colors.valid && !(char_beat && chars.last_char)) |=> !colors.valid)
		else $error("color beat without a final byte");

endmodule
